>>> rtl/core/rmr_pkg.sv
// Package with the types and codes shared by the room membership router.
package rmr_pkg;

    localparam logic [1:0] OP_JOIN   = 2'd0;
    localparam logic [1:0] OP_RELAY  = 2'd1;
    localparam logic [1:0] OP_DISC   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ROLE   = 2'd0;
    localparam logic [1:0] KIND_JOINED = 2'd1;
    localparam logic [1:0] KIND_LEFT   = 2'd2;
    localparam logic [1:0] KIND_RELAY  = 2'd3;

    localparam logic [1:0] REG_MAX_ROOMS   = 2'd0;
    localparam logic [1:0] REG_MAX_MEMBERS = 2'd1;
    localparam logic [1:0] REG_MAX_SIGNAL  = 2'd2;

    localparam logic [15:0] PEER_FIELD_BYTES = 16'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RSCAN,
        ST_MSCAN,
        ST_DECIDE,
        ST_HSCAN,
        ST_EMIT,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] dest;
        logic        host;
        logic [31:0] peer;
        logic [15:0] size;
        logic        last;
    } result_t;

endpackage

>>> rtl/core/rmr_out_reg.sv
// Output register that holds one result item until the receiver takes it.
module rmr_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rmr_pkg::result_t din,
    output logic             full,
    input  logic             stall,
    output logic             valid,
    output rmr_pkg::result_t dout
);
    logic             full_reg;
    rmr_pkg::result_t data_reg;

    // Load when empty or when the held item leaves in this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
        end
        else if (!stall)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign full  = full_reg && stall;
    assign valid = full_reg;
    assign dout  = data_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(full_reg && stall))
        else $error("result loaded over a held item");
`endif
endmodule

>>> rtl/core/room_membership_router.sv
// Top level of the room membership router: sequencer over room and member memories.
// A join, relay or disconnect scans the room table and each used room's members,
// one memory read at a time (issue, then check the registered data).
// The router takes one item at a time; each item also emits its results, walks the members
// after the search for a host relay or disconnect, and shifts the members on a member
// disconnect; output stalls hold the sequencer.
// Reset: valid bits and member counts clear at once; configuration resets to 16, 8, 1024.
module room_membership_router
#(
    parameter int MAX_ROOMS   = 16,
    parameter int MAX_MEMBERS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] conn_id,
    input  logic [31:0] room_code,
    input  logic [31:0] target_peer,
    input  logic [15:0] payload_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  msg_kind,
    output logic [15:0] dest_conn,
    output logic        role_is_host,
    output logic [31:0] peer_field,
    output logic [15:0] out_size,
    output logic        last
);
    localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int NW = $clog2(MAX_ROOMS + 1);
    localparam int SLOTS = MAX_ROOMS * (2 ** MW);
    localparam int SW = RW + MW;

    // Configuration registers.
    logic [4:0]  max_rooms_reg;
    logic [3:0]  max_members_reg;
    logic [15:0] max_signal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rooms_reg   <= 5'd16;
            max_members_reg <= 4'd8;
            max_signal_reg  <= 16'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmr_pkg::REG_MAX_ROOMS:   max_rooms_reg   <= cfg_data[4:0];
                rmr_pkg::REG_MAX_MEMBERS: max_members_reg <= cfg_data[3:0];
                rmr_pkg::REG_MAX_SIGNAL:  max_signal_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flip-flop state: valid bits and member counts.
    logic [MAX_ROOMS-1:0] used_reg, used_next;
    logic [CW-1:0]        cnt_reg [MAX_ROOMS];
    logic                 cnt_we;
    logic [RW-1:0]        cnt_wa;
    logic [CW-1:0]        cnt_wd;

    // Room memory: key, host, counter.
    logic [79:0]   room_mem [MAX_ROOMS];
    logic [79:0]   room_rd;
    logic [RW-1:0] room_ra;
    logic          room_we;
    logic [RW-1:0] room_wa;
    logic [79:0]   room_wd;

    always_ff @(posedge clk)
    begin
        if (room_we)
        begin
            room_mem[room_wa] <= room_wd;
        end
        room_rd <= room_mem[room_ra];
    end

    // Member memory: conn, peer.
    logic [47:0]   mem_mem [SLOTS];
    logic [47:0]   mem_rd;
    logic [SW-1:0] mem_ra;
    logic          mem_we;
    logic [SW-1:0] mem_wa;
    logic [47:0]   mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_mem[mem_wa] <= mem_wd;
        end
        mem_rd <= mem_mem[mem_ra];
    end

    // Sequencer registers.
    rmr_pkg::state_t state_reg, state_next;
    logic [1:0]   op_reg;
    logic [15:0]  conn_reg;
    logic [31:0]  code_reg, tgt_reg;
    logic [15:0]  size_reg;
    logic [RW:0]  ri_reg, ri_next;       // room scan index, one wider to hold the end
    logic [CW-1:0] mi_reg, mi_next;      // member index
    logic         rpend_reg, rpend_next; // room read data due
    logic         mpend_reg, mpend_next; // member read data due
    logic         found_reg, found_next;
    logic         ishost_reg, ishost_next;
    logic [RW-1:0] froom_reg, froom_next;
    logic [MW-1:0] fpos_reg, fpos_next;
    logic         kfound_reg, kfound_next;
    logic [RW-1:0] kroom_reg, kroom_next;
    logic [79:0]  rdata_reg, rdata_next;
    logic [31:0]  fpeer_reg, fpeer_next;
    logic [NW-1:0] nused;
    logic [RW:0]  free_idx;
    logic         free_ok;
    logic [2:0]   nres_reg, nres_next;   // results left to emit in ST_EMIT
    logic [1:0]   emode_reg, emode_next;

    localparam logic [1:0] EM_FIXED = 2'd0;
    localparam logic [1:0] EM_LEFT  = 2'd1;

    rmr_pkg::result_t res_a_reg, res_a_next, res_b_reg, res_b_next;
    rmr_pkg::result_t load_data;
    logic load, ob_full;

    logic [CW-1:0] cur_cnt;
    logic [RW-1:0] ri_s;
    logic [4:0]    room_cap;
    logic [3:0]    mem_cap;
    logic [16:0]   size_lim;

    assign ri_s     = ri_reg[RW-1:0];
    assign cur_cnt  = cnt_reg[froom_reg];
    assign room_cap = (int'(max_rooms_reg) < MAX_ROOMS) ? max_rooms_reg : 5'(MAX_ROOMS);
    assign mem_cap  = (int'(max_members_reg) < MAX_MEMBERS) ? max_members_reg
                                                              : 4'(MAX_MEMBERS);
    assign size_lim = {1'b0, max_signal_reg} + 17'(rmr_pkg::PEER_FIELD_BYTES);

    // Count of used rooms and lowest free slot.
    always_comb
    begin
        nused    = '0;
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = 0; i < MAX_ROOMS; i++)
        begin
            nused = nused + NW'(used_reg[i]);
            if (!used_reg[i] && !free_ok)
            begin
                free_ok  = 1'b1;
                free_idx = (RW+1)'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmr_pkg::ST_IDLE;
            used_reg  <= '0;
            rpend_reg <= 1'b0;
            mpend_reg <= 1'b0;
            for (int i = 0; i < MAX_ROOMS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            rpend_reg <= rpend_next;
            mpend_reg <= mpend_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_wa] <= cnt_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rmr_pkg::ST_IDLE && in_valid)
        begin
            op_reg   <= op;
            conn_reg <= conn_id;
            code_reg <= room_code;
            tgt_reg  <= target_peer;
            size_reg <= payload_size;
        end
        ri_reg     <= ri_next;
        mi_reg     <= mi_next;
        found_reg  <= found_next;
        ishost_reg <= ishost_next;
        froom_reg  <= froom_next;
        fpos_reg   <= fpos_next;
        kfound_reg <= kfound_next;
        kroom_reg  <= kroom_next;
        rdata_reg  <= rdata_next;
        fpeer_reg  <= fpeer_next;
        nres_reg   <= nres_next;
        emode_reg  <= emode_next;
        res_a_reg  <= res_a_next;
        res_b_reg  <= res_b_next;
    end

    // Decision after the connection search.
    function automatic rmr_pkg::state_t decide_state();
        rmr_pkg::state_t s;
        s = rmr_pkg::ST_IDLE;
        case (op_reg)
            rmr_pkg::OP_JOIN:
                if (!found_reg)
                begin
                    s = rmr_pkg::ST_EMIT;
                    if (!kfound_reg && (int'(nused) >= int'(room_cap) || !free_ok))
                    begin
                        s = rmr_pkg::ST_IDLE;
                    end
                    if (kfound_reg && int'(cnt_reg[kroom_reg]) >= int'(mem_cap))
                    begin
                        s = rmr_pkg::ST_IDLE;
                    end
                end
            rmr_pkg::OP_RELAY:
                if (found_reg && size_reg >= rmr_pkg::PEER_FIELD_BYTES
                    && {1'b0, size_reg} <= size_lim)
                begin
                    s = ishost_reg ? rmr_pkg::ST_HSCAN : rmr_pkg::ST_EMIT;
                end
            rmr_pkg::OP_DISC:
                if (found_reg)
                begin
                    s = ishost_reg ? ((cur_cnt == '0) ? rmr_pkg::ST_DONE : rmr_pkg::ST_HSCAN)
                                   : rmr_pkg::ST_EMIT;
                end
            default: s = rmr_pkg::ST_IDLE;
        endcase
        return s;
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmr_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = (op == rmr_pkg::OP_UNUSED) ? rmr_pkg::ST_IDLE
                                                             : rmr_pkg::ST_RSCAN;
                end
            rmr_pkg::ST_RSCAN:
                if (rpend_reg && used_reg[froom_next] && room_rd[47:32] == conn_reg)
                begin
                    state_next = rmr_pkg::ST_DECIDE;
                end
                else if (rpend_reg && used_reg[ri_reg[RW-1:0] - RW'(1)]
                         && cnt_reg[ri_reg[RW-1:0] - RW'(1)] != '0)
                begin
                    state_next = rmr_pkg::ST_MSCAN;
                end
                else if (!rpend_reg && ri_reg == (RW+1)'(MAX_ROOMS))
                begin
                    state_next = rmr_pkg::ST_DECIDE;
                end
            rmr_pkg::ST_MSCAN:
                if (mpend_reg && mem_rd[47:32] == conn_reg)
                begin
                    state_next = rmr_pkg::ST_DECIDE;
                end
                else if (!mpend_reg && mi_reg == cur_cnt)
                begin
                    state_next = (ri_reg == (RW+1)'(MAX_ROOMS)) ? rmr_pkg::ST_DECIDE
                                                                  : rmr_pkg::ST_RSCAN;
                end
            rmr_pkg::ST_DECIDE:
                state_next = decide_state();
            rmr_pkg::ST_HSCAN:
                if (!mpend_reg && (mi_reg == cur_cnt || nres_reg != 3'd0))
                begin
                    state_next = (nres_reg != 3'd0) ? rmr_pkg::ST_EMIT : rmr_pkg::ST_IDLE;
                end
            rmr_pkg::ST_EMIT:
                if (!ob_full && nres_reg == 3'd1)
                begin
                    state_next = (emode_reg == EM_LEFT) ? rmr_pkg::ST_SHIFT : rmr_pkg::ST_DONE;
                end
            rmr_pkg::ST_SHIFT:
                if (!mpend_reg && mi_reg + CW'(1) >= cur_cnt)
                begin
                    state_next = rmr_pkg::ST_DONE;
                end
            rmr_pkg::ST_DONE:
                state_next = rmr_pkg::ST_IDLE;
            default:
                state_next = rmr_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        ri_next     = ri_reg;
        mi_next     = mi_reg;
        rpend_next  = 1'b0;
        mpend_next  = 1'b0;
        found_next  = found_reg;
        ishost_next = ishost_reg;
        froom_next  = froom_reg;
        fpos_next   = fpos_reg;
        kfound_next = kfound_reg;
        kroom_next  = kroom_reg;
        rdata_next  = rdata_reg;
        fpeer_next  = fpeer_reg;
        nres_next   = nres_reg;
        emode_next  = emode_reg;
        res_a_next  = res_a_reg;
        res_b_next  = res_b_reg;
        used_next   = used_reg;
        room_ra     = ri_s;
        room_we     = 1'b0;
        room_wa     = froom_reg;
        room_wd     = rdata_reg;
        mem_ra      = {froom_reg, mi_reg[MW-1:0]};
        mem_we      = 1'b0;
        mem_wa      = {froom_reg, mi_reg[MW-1:0]};
        mem_wd      = '0;
        cnt_we      = 1'b0;
        cnt_wa      = froom_reg;
        cnt_wd      = '0;
        load        = 1'b0;
        load_data   = res_a_reg;
        case (state_reg)
            rmr_pkg::ST_IDLE:
            begin
                ri_next     = '0;
                found_next  = 1'b0;
                kfound_next = 1'b0;
                nres_next   = '0;
                emode_next  = EM_FIXED;
            end
            rmr_pkg::ST_RSCAN:
            begin
                // Check the room read in the previous cycle.
                if (rpend_reg)
                begin
                    froom_next = ri_s - RW'(1);
                    rdata_next = room_rd;
                    mi_next    = '0;
                    if (used_reg[froom_next])
                    begin
                        if (room_rd[79:48] == code_reg && !kfound_reg)
                        begin
                            kfound_next = 1'b1;
                            kroom_next  = froom_next;
                        end
                        if (room_rd[47:32] == conn_reg)
                        begin
                            found_next  = 1'b1;
                            ishost_next = 1'b1;
                        end
                    end
                end
                else if (ri_reg != (RW+1)'(MAX_ROOMS))
                begin
                    room_ra    = ri_s;
                    rpend_next = 1'b1;
                    ri_next    = ri_reg + (RW+1)'(1);
                end
            end
            rmr_pkg::ST_MSCAN:
            begin
                if (mpend_reg)
                begin
                    if (mem_rd[47:32] == conn_reg)
                    begin
                        found_next  = 1'b1;
                        ishost_next = 1'b0;
                        fpos_next   = MW'(mi_reg - CW'(1));
                        fpeer_next  = mem_rd[31:0];
                    end
                end
                else if (mi_reg != cur_cnt)
                begin
                    mem_ra     = {froom_reg, mi_reg[MW-1:0]};
                    mpend_next = 1'b1;
                    mi_next    = mi_reg + CW'(1);
                end
            end
            rmr_pkg::ST_DECIDE:
            begin
                mi_next = '0;
                case (op_reg)
                    rmr_pkg::OP_JOIN:
                    begin
                        if (!kfound_reg)
                        begin
                            froom_next = free_idx[RW-1:0];
                            res_a_next = '{rmr_pkg::KIND_ROLE, conn_reg, 1'b1, 32'd0,
                                           16'd0, 1'b1};
                            nres_next  = 3'd1;
                            if (decide_state() == rmr_pkg::ST_EMIT)
                            begin
                                used_next[free_idx[RW-1:0]] = 1'b1;
                                room_we = 1'b1;
                                room_wa = free_idx[RW-1:0];
                                room_wd = {code_reg, conn_reg, 32'd1};
                                cnt_we  = 1'b1;
                                cnt_wa  = free_idx[RW-1:0];
                                cnt_wd  = '0;
                            end
                        end
                        else
                        begin
                            // The room data of the key match is read again below.
                            froom_next = kroom_reg;
                            room_ra    = kroom_reg;
                            nres_next  = 3'd2;
                        end
                    end
                    rmr_pkg::OP_RELAY:
                    begin
                        res_a_next = '{rmr_pkg::KIND_RELAY, rdata_reg[47:32], 1'b0,
                                       fpeer_reg, size_reg, 1'b1};
                        nres_next  = ishost_reg ? 3'd0 : 3'd1;
                    end
                    rmr_pkg::OP_DISC:
                    begin
                        res_a_next = '{rmr_pkg::KIND_LEFT, rdata_reg[47:32], 1'b0,
                                       fpeer_reg, 16'd0, 1'b1};
                        nres_next  = ishost_reg ? 3'd0 : 3'd1;
                        emode_next = ishost_reg ? EM_FIXED : EM_LEFT;
                        mi_next    = ishost_reg ? '0 : CW'(fpos_reg);
                        if (ishost_reg)
                        begin
                            used_next[froom_reg] = 1'b0;
                            cnt_we = (cur_cnt == '0);
                        end
                    end
                    default: ;
                endcase
            end
            rmr_pkg::ST_HSCAN:
            begin
                // Host relay: find the target; host disconnect: send to every member.
                if (mpend_reg)
                begin
                    if (op_reg == rmr_pkg::OP_RELAY)
                    begin
                        if (mem_rd[31:0] == tgt_reg)
                        begin
                            res_a_next = '{rmr_pkg::KIND_RELAY, mem_rd[47:32], 1'b0, 32'd0,
                                           size_reg, 1'b1};
                            nres_next  = 3'd1;
                        end
                    end
                    else
                    begin
                        res_a_next = '{rmr_pkg::KIND_LEFT, mem_rd[47:32], 1'b0, 32'd0,
                                       16'd0, mi_reg == cur_cnt};
                        load_data  = res_a_next;
                    end
                end
                else if (mi_reg != cur_cnt && nres_reg == 3'd0 && !ob_full)
                begin
                    mem_ra     = {froom_reg, mi_reg[MW-1:0]};
                    mpend_next = 1'b1;
                    mi_next    = mi_reg + CW'(1);
                end
                if (mpend_reg && op_reg == rmr_pkg::OP_DISC)
                begin
                    load = 1'b1;
                end
                // The room is emptied on the cycle that ends the walk.
                if (!mpend_reg && mi_reg == cur_cnt && op_reg == rmr_pkg::OP_DISC)
                begin
                    cnt_we = 1'b1;
                end
            end
            rmr_pkg::ST_EMIT:
            begin
                if (op_reg == rmr_pkg::OP_JOIN && kfound_reg && nres_reg == 3'd2)
                begin
                    // Room record arrives; append the member and build both results.
                    res_a_next = '{rmr_pkg::KIND_ROLE, conn_reg, 1'b0, room_rd[31:0],
                                   16'd0, 1'b0};
                    res_b_next = '{rmr_pkg::KIND_JOINED, room_rd[47:32], 1'b0,
                                   room_rd[31:0], 16'd0, 1'b1};
                    room_we = 1'b1;
                    room_wd = {room_rd[79:32], room_rd[31:0] + 32'd1};
                    mem_we  = 1'b1;
                    mem_wa  = {froom_reg, cur_cnt[MW-1:0]};
                    mem_wd  = {conn_reg, room_rd[31:0]};
                    cnt_we  = 1'b1;
                    cnt_wd  = cur_cnt + CW'(1);
                    nres_next = 3'd3;
                end
                else if (!ob_full)
                begin
                    load      = 1'b1;
                    load_data = res_a_reg;
                    if (nres_reg == 3'd3)
                    begin
                        res_a_next = res_b_reg;
                        nres_next  = 3'd1;
                    end
                    else
                    begin
                        nres_next = nres_reg - 3'd1;
                    end
                end
            end
            rmr_pkg::ST_SHIFT:
            begin
                // Close the gap left by a departing member, one entry per read.
                if (mpend_reg)
                begin
                    mem_we  = 1'b1;
                    mem_wa  = {froom_reg, MW'(mi_reg - CW'(1))};
                    mem_wd  = mem_rd;
                end
                else if (mi_reg + CW'(1) < cur_cnt)
                begin
                    mem_ra     = {froom_reg, MW'(mi_reg + CW'(1))};
                    mpend_next = 1'b1;
                    mi_next    = mi_reg + CW'(1);
                end
                else
                begin
                    cnt_we = 1'b1;
                    cnt_wd = cur_cnt - CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign in_stall = (state_reg != rmr_pkg::ST_IDLE);

    rmr_pkg::result_t ob_dout;

    rmr_out_reg u_out
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .din   (load_data),
        .full  (ob_full),
        .stall (out_stall),
        .valid (out_valid),
        .dout  (ob_dout)
    );

    assign msg_kind     = ob_dout.kind;
    assign dest_conn    = ob_dout.dest;
    assign role_is_host = ob_dout.host;
    assign peer_field   = ob_dout.peer;
    assign out_size     = ob_dout.size;
    assign last         = ob_dout.last;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rmr_pkg::ST_IDLE) |-> in_stall)
        else $error("item accepted while busy");
    a_one_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !(rpend_reg && mpend_reg))
        else $error("two reads in flight");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |=> (cnt_reg[$past(cnt_wa)] <= CW'(MAX_MEMBERS)))
        else $error("member count over capacity");
`endif
endmodule
